FILE: hw/rtl/sbp_pkg.sv
// shared types, constants and the byte-wide crc-16-ccitt update for the frame receiver
// no dependencies
`default_nettype none

package sbp_pkg;

    // fixed framing constants
    localparam logic [7:0] PREAMBLE_BYTE = 8'h55;
    localparam logic [7:0] FIELD_BYTES   = 8'd2;
    localparam logic [15:0] CRC_POLY     = 16'h1021;

    // result event codes
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PAYLOAD = 2'd1,
        EV_GOOD    = 2'd2,
        EV_CRC_ERR = 2'd3
    } t_event;

    // deframing phase, one-hot
    typedef enum logic [5:0] {
        PH_HUNT    = 6'b000001,
        PH_TYPE    = 6'b000010,
        PH_SENDER  = 6'b000100,
        PH_LENGTH  = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_CRC     = 6'b100000
    } t_phase;

    // crc-16-ccitt, msb first, one byte folded in
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sbp_frame_receiver.sv
// binary frame receiver: preamble hunt, header capture, payload pass-out, crc check
// depends on sbp_pkg
`default_nettype none

// Takes one received byte per item and gives exactly one result item per byte, so a
// new byte can be taken in every cycle: the phase logic and the byte-wide crc update
// sit between the frame state registers and a single result register. A result that
// waits on a stalled output holds the input back only while the result register is
// full and stalled; otherwise each byte's result appears on the cycle after it is
// taken. Event 1 carries a payload byte and its index, event 2 marks a good frame
// (header fields shown, then cleared), event 3 a crc mismatch (fields kept until the
// next preamble). Header bytes, the first crc byte and bytes outside a frame: event 0.
module sbp_frame_receiver
    import sbp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input
    input  wire logic        i_rx_valid,
    output logic             o_rx_stall,
    input  wire logic [7:0]  i_rx_byte,
    // result output
    output logic             o_res_valid,
    input  wire logic        i_res_stall,
    output logic [1:0]       o_event_res,
    output logic [7:0]       o_data_byte,
    output logic [7:0]       o_byte_index,
    output logic [15:0]      o_msg_type,
    output logic [15:0]      o_sender_id,
    output logic [7:0]       o_payload_len
);

    // frame state
    t_phase      r_phase,      n_phase;
    logic [7:0]  r_count,      n_count;
    logic [15:0] r_type,       n_type;
    logic [15:0] r_sender,     n_sender;
    logic [7:0]  r_length,     n_length;
    logic [15:0] r_crc,        n_crc;
    logic [7:0]  r_crc_low,    n_crc_low;

    // result register
    logic        r_res_valid;
    t_event      r_event,      n_event;
    logic [7:0]  r_data,       n_data;
    logic [7:0]  r_index,      n_index;
    logic [15:0] r_out_type;
    logic [15:0] r_out_sender;
    logic [7:0]  r_out_length;

    logic        take;
    logic        good_end;
    logic [7:0]  count_inc;
    logic [15:0] crc_next;
    logic [15:0] rx_crc;

    // input is held back only while a finished result is stalled
    assign o_rx_stall = r_res_valid && i_res_stall;
    assign take       = i_rx_valid && !o_rx_stall;

    assign count_inc = r_count + 8'd1;
    assign crc_next  = crc_feed(r_crc, i_rx_byte);
    assign rx_crc    = {i_rx_byte, r_crc_low};

    // phase logic for one byte
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_type    = r_type;
        n_sender  = r_sender;
        n_length  = r_length;
        n_crc     = r_crc;
        n_crc_low = r_crc_low;
        n_event   = EV_NONE;
        n_data    = 8'd0;
        n_index   = 8'd0;
        good_end  = 1'b0;
        unique case (r_phase)
            PH_TYPE: begin
                if (r_count[0]) begin
                    n_type[15:8] = i_rx_byte;
                end else begin
                    n_type[7:0] = i_rx_byte;
                end
                n_crc   = crc_next;
                n_count = count_inc;
                if (count_inc >= FIELD_BYTES) begin
                    n_count = 8'd0;
                    n_phase = PH_SENDER;
                end
            end
            PH_SENDER: begin
                if (r_count[0]) begin
                    n_sender[15:8] = i_rx_byte;
                end else begin
                    n_sender[7:0] = i_rx_byte;
                end
                n_crc   = crc_next;
                n_count = count_inc;
                if (count_inc >= FIELD_BYTES) begin
                    n_count = 8'd0;
                    n_phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                n_length = i_rx_byte;
                n_crc    = crc_next;
                n_count  = 8'd0;
                n_phase  = (i_rx_byte == 8'd0) ? PH_CRC : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_event = EV_PAYLOAD;
                n_data  = i_rx_byte;
                n_index = r_count;
                n_crc   = crc_next;
                n_count = count_inc;
                if (count_inc >= r_length) begin
                    n_count = 8'd0;
                    n_phase = PH_CRC;
                end
            end
            PH_CRC: begin
                if (r_count == 8'd0) begin
                    n_crc_low = i_rx_byte;
                    n_count   = 8'd1;
                end else begin
                    if (rx_crc == r_crc) begin
                        n_event  = EV_GOOD;
                        good_end = 1'b1;
                    end else begin
                        n_event = EV_CRC_ERR;
                    end
                    n_count = 8'd0;
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                // hunting, also any stray phase code
                n_phase = PH_HUNT;
                if (i_rx_byte == PREAMBLE_BYTE) begin
                    n_count  = 8'd0;
                    n_crc    = 16'd0;
                    n_type   = 16'd0;
                    n_sender = 16'd0;
                    n_length = 8'd0;
                    n_phase  = PH_TYPE;
                end
            end
        endcase
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_count   <= 8'd0;
            r_type    <= 16'd0;
            r_sender  <= 16'd0;
            r_length  <= 8'd0;
            r_crc     <= 16'd0;
            r_crc_low <= 8'd0;
        end else if (take) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_crc     <= n_crc;
            r_crc_low <= n_crc_low;
            // a good frame shows its header once, then the header clears
            r_type    <= good_end ? 16'd0 : n_type;
            r_sender  <= good_end ? 16'd0 : n_sender;
            r_length  <= good_end ? 8'd0  : n_length;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (take) begin
            r_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_res_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_event      <= n_event;
            r_data       <= n_data;
            r_index      <= n_index;
            r_out_type   <= n_type;
            r_out_sender <= n_sender;
            r_out_length <= n_length;
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_event_res   = r_event;
    assign o_data_byte   = r_data;
    assign o_byte_index  = r_index;
    assign o_msg_type    = r_out_type;
    assign o_sender_id   = r_out_sender;
    assign o_payload_len = r_out_length;

endmodule

`default_nettype wire

FILE: hw/rtl/sbp_checker.sv
// port-level checks for the frame receiver, bound to sbp_frame_receiver
// depends on sbp_pkg and sbp_frame_receiver
`default_nettype none

module sbp_checker
    import sbp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_rx_valid,
    input wire logic        o_rx_stall,
    input wire logic        o_res_valid,
    input wire logic        i_res_stall,
    input wire logic [1:0]  o_event_res,
    input wire logic [7:0]  o_data_byte,
    input wire logic [7:0]  o_byte_index,
    input wire logic [7:0]  o_payload_len
);

    // a stalled result item holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_event_res)
            && $stable(o_data_byte) && $stable(o_byte_index))
        else $error("stalled result changed");

    // every accepted byte yields a result on the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rx_valid && !o_rx_stall |=> o_res_valid)
        else $error("accepted byte gave no result");

    // data and index are zero unless a payload byte is shown
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_event_res != EV_PAYLOAD |-> o_data_byte == 8'd0
            && o_byte_index == 8'd0)
        else $error("data fields set outside payload");

    // a payload byte lies within the announced length
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_event_res == EV_PAYLOAD |-> o_byte_index < o_payload_len)
        else $error("payload index beyond length");

endmodule

bind sbp_frame_receiver sbp_checker u_sbp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rx_valid    (i_rx_valid),
    .o_rx_stall    (o_rx_stall),
    .o_res_valid   (o_res_valid),
    .i_res_stall   (i_res_stall),
    .o_event_res   (o_event_res),
    .o_data_byte   (o_data_byte),
    .o_byte_index  (o_byte_index),
    .o_payload_len (o_payload_len)
);

`default_nettype wire
